FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: rtl/slb_pkg.sv
`default_nettype none

package slb_pkg;

   localparam int LEN_W       = 16;
   localparam int FRAC_W      = 24;
   localparam int SMOOTH_W    = 40;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 14;
   localparam int GLIDE_SPLIT = 20;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BLEND  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLIDE_RATE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEZE        = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11469;

   typedef struct packed {
      logic rd;
      logic wr;
   } slb_mem_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/slb_loop_mem.sv
`default_nettype none

module slb_loop_mem
   import slb_pkg::*;
#(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int SB    = 24
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire slb_mem_ctl_type ctl,
   input  wire logic [AW-1:0]   addr,
   input  wire logic [2*SB-1:0] wr_held,
   input  wire logic [2*SB-1:0] wr_cap,
   output logic      [2*SB-1:0] rd_held,
   output logic      [2*SB-1:0] rd_cap
);

   logic [2*SB-1:0] held_mem [DEPTH];
   logic [2*SB-1:0] cap_mem  [DEPTH];

   logic [2*SB-1:0] held_q_ff;
   logic [2*SB-1:0] cap_q_ff;
   logic            rd_valid_ff;
   logic            rd_valid_in;
   logic [AW:0]     fill_ff;
   logic [AW:0]     fill_in;

   // entries at or above the fill mark were never written and read as zero
   always_comb begin
      rd_valid_in = rd_valid_ff;
      fill_in     = fill_ff;
      if (ctl.rd) begin
         rd_valid_in = ({1'b0, addr} < fill_ff);
      end
      if (ctl.wr && ({1'b0, addr} >= fill_ff)) begin
         fill_in = {1'b0, addr} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         held_q_ff <= held_mem[addr];
         cap_q_ff  <= cap_mem[addr];
      end
      if (ctl.wr) begin
         held_mem[addr] <= wr_held;
         cap_mem[addr]  <= wr_cap;
      end
   end

   assign rd_held = rd_valid_ff ? held_q_ff : '0;
   assign rd_cap  = rd_valid_ff ? cap_q_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/stereo_loop_blur.sv
`default_nettype none
`include "assert_macros.svh"

// Stereo loop blur. One stereo pair in, one pair out per transaction. The
// result register is loaded after these steps following acceptance: a read of the loop
// memories at the current position, the glide products for length and blend
// (the 40-bit length distance is multiplied in two halves), the update of the
// smoothed values, the blend multiply, the write-back of held and captured
// values, the gain multiply and the saturation. A new transaction is taken the
// cycle after the previous result is loaded, so no pair is taken before the
// last one is through; the load waits while the output is stalled. The loop
// memories need no clearing pass after reset: a fill mark treats every entry
// above the highest position yet written as zero. The user must write registers
// over the csr port only while no transaction is in flight; the block does not enforce it.
module stereo_loop_blur
   import slb_pkg::*;
#(
   parameter int LOOP_DEPTH  = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed      [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed      [SAMPLE_BITS-1:0] rsp_right_out,
   input  wire logic                          csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int AW    = $clog2(LOOP_DEPTH);
   localparam int PW    = AW + 1;
   localparam int CMP_W = (PW > LEN_W) ? PW : LEN_W;
   localparam int LO_W  = GLIDE_SPLIT;
   localparam int HI_W  = SMOOTH_W - GLIDE_SPLIT;
   localparam int GL_W  = SMOOTH_W + FRAC_W;
   localparam int BP_W  = SB + FRAC_W;
   localparam int GP_W  = SB + GAIN_W;
   localparam int GM_W  = GP_W - GAIN_FRAC;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL1  = 3'd1;
   localparam logic [2:0] ST_MUL2  = 3'd2;
   localparam logic [2:0] ST_BLEND = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;
   localparam logic [2:0] ST_GAIN  = 3'd5;
   localparam logic [2:0] ST_SAT   = 3'd6;

   localparam logic [GM_W-1:0] POS_LIM = {{(GM_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic [GM_W-1:0] NEG_LIM = {{(GM_W-SB){1'b0}}, 1'b1, {(SB-1){1'b0}}};
   localparam logic [SB-1:0]   OUT_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0]   OUT_MIN = {1'b1, {(SB-1){1'b0}}};

   // control state
   logic [2:0]          state_ff, state_in;
   logic [LEN_W-1:0]    tlen_ff, tlen_in;
   logic [FRAC_W-1:0]   tblend_ff, tblend_in;
   logic [FRAC_W-1:0]   rate_ff, rate_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                freeze_ff, freeze_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [SMOOTH_W-1:0] slen_ff, slen_in;
   logic [FRAC_W-1:0]   sblend_ff, sblend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [SB-1:0] in_l_ff, in_l_in, in_r_ff, in_r_in;
   logic [SMOOTH_W-1:0]  dlen_mag_ff, dlen_mag_in;
   logic                 dlen_neg_ff, dlen_neg_in;
   logic [FRAC_W-1:0]    dbl_mag_ff, dbl_mag_in;
   logic                 dbl_neg_ff, dbl_neg_in;
   logic [LO_W+FRAC_W-1:0] plo_ff, plo_in;
   logic [HI_W+FRAC_W-1:0] phi_ff, phi_in;
   logic [2*FRAC_W-1:0]  pbl_ff, pbl_in;
   logic signed [SB-1:0] held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic signed [SB-1:0] cap_l_ff, cap_l_in, cap_r_ff, cap_r_in;
   logic [SB-1:0]        dl_mag_ff, dl_mag_in, dr_mag_ff, dr_mag_in;
   logic                 dl_neg_ff, dl_neg_in, dr_neg_ff, dr_neg_in;
   logic [BP_W-1:0]      bl_prod_ff, bl_prod_in, br_prod_ff, br_prod_in;
   logic signed [SB-1:0] hnew_l_ff, hnew_l_in, hnew_r_ff, hnew_r_in;
   logic [GP_W-1:0]      gl_prod_ff, gl_prod_in, gr_prod_ff, gr_prod_in;
   logic signed [SB-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;

   // combinational helpers
   logic                 accept;
   logic                 out_load;
   logic [SMOOTH_W-1:0]  tlen_wide;
   logic [GL_W-1:0]      glide_sum;
   logic [SMOOTH_W-1:0]  slen_step;
   logic [FRAC_W-1:0]    sblend_step;
   logic [SB-1:0]        step_l, step_r;
   logic signed [SB-1:0] hold_l, hold_r;
   logic [SB-1:0]        abs_l, abs_r;
   logic [GM_W-1:0]      gmag_l, gmag_r;
   logic [PW-1:0]        pos_next;
   logic [LEN_W-1:0]     len_int;
   logic                 pos_wrap;

   slb_mem_ctl_type      mem_ctl;
   logic [2*SB-1:0]      mem_rd_held, mem_rd_cap;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign out_load  = (state_ff == ST_SAT) && (!rsp_valid_ff || !rsp_stall);

   assign tlen_wide   = {tlen_ff, {FRAC_W{1'b0}}};
   assign glide_sum   = {phi_ff, {LO_W{1'b0}}} + GL_W'(plo_ff);
   assign slen_step   = glide_sum[GL_W-1:FRAC_W];
   assign sblend_step = pbl_ff[2*FRAC_W-1:FRAC_W];
   assign step_l      = bl_prod_ff[BP_W-1:FRAC_W];
   assign step_r      = br_prod_ff[BP_W-1:FRAC_W];
   assign hold_l      = dl_neg_ff ? (held_l_ff - $signed(step_l)) : (held_l_ff + $signed(step_l));
   assign hold_r      = dr_neg_ff ? (held_r_ff - $signed(step_r)) : (held_r_ff + $signed(step_r));
   assign abs_l       = hnew_l_ff[SB-1] ? SB'(-hnew_l_ff) : SB'(hnew_l_ff);
   assign abs_r       = hnew_r_ff[SB-1] ? SB'(-hnew_r_ff) : SB'(hnew_r_ff);
   assign gmag_l      = gl_prod_ff[GP_W-1:GAIN_FRAC];
   assign gmag_r      = gr_prod_ff[GP_W-1:GAIN_FRAC];

   // position advances on the updated smoothed length
   assign len_int  = slen_ff[SMOOTH_W-1:FRAC_W];
   assign pos_next = {1'b0, pos_ff} + 1'b1;
   assign pos_wrap = (CMP_W'(pos_next) >= CMP_W'(len_int)) || (pos_next >= PW'(LOOP_DEPTH));

   assign mem_ctl.rd = accept;
   assign mem_ctl.wr = (state_ff == ST_HOLD);

   slb_loop_mem #(
      .DEPTH (LOOP_DEPTH),
      .AW    (AW),
      .SB    (SB)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (pos_ff),
      .wr_held ({hold_l, hold_r}),
      .wr_cap  ({cap_l_ff, cap_r_ff}),
      .rd_held (mem_rd_held),
      .rd_cap  (mem_rd_cap)
   );

   always_comb begin
      state_in     = state_ff;
      tlen_in      = tlen_ff;
      tblend_in    = tblend_ff;
      rate_in      = rate_ff;
      gain_in      = gain_ff;
      freeze_in    = freeze_ff;
      pos_in       = pos_ff;
      slen_in      = slen_ff;
      sblend_in    = sblend_ff;
      rsp_valid_in = rsp_valid_ff;

      in_l_in     = in_l_ff;
      in_r_in     = in_r_ff;
      dlen_mag_in = dlen_mag_ff;
      dlen_neg_in = dlen_neg_ff;
      dbl_mag_in  = dbl_mag_ff;
      dbl_neg_in  = dbl_neg_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      pbl_in      = pbl_ff;
      held_l_in   = held_l_ff;
      held_r_in   = held_r_ff;
      cap_l_in    = cap_l_ff;
      cap_r_in    = cap_r_ff;
      dl_mag_in   = dl_mag_ff;
      dr_mag_in   = dr_mag_ff;
      dl_neg_in   = dl_neg_ff;
      dr_neg_in   = dr_neg_ff;
      bl_prod_in  = bl_prod_ff;
      br_prod_in  = br_prod_ff;
      hnew_l_in   = hnew_l_ff;
      hnew_r_in   = hnew_r_ff;
      gl_prod_in  = gl_prod_ff;
      gr_prod_in  = gr_prod_ff;
      out_l_in    = out_l_ff;
      out_r_in    = out_r_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_LENGTH: tlen_in   = csr_wdata[LEN_W-1:0];
            CSR_TARGET_BLEND:  tblend_in = csr_wdata[FRAC_W-1:0];
            CSR_GLIDE_RATE:    rate_in   = csr_wdata[FRAC_W-1:0];
            CSR_OUTPUT_GAIN:   gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_FREEZE:        freeze_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_l_in     = req_left_sample;
               in_r_in     = req_right_sample;
               dlen_neg_in = (tlen_wide < slen_ff);
               dlen_mag_in = (tlen_wide < slen_ff) ? (slen_ff - tlen_wide)
                                                   : (tlen_wide - slen_ff);
               dbl_neg_in  = (tblend_ff < sblend_ff);
               dbl_mag_in  = (tblend_ff < sblend_ff) ? (sblend_ff - tblend_ff)
                                                     : (tblend_ff - sblend_ff);
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            plo_in    = (LO_W+FRAC_W)'(dlen_mag_ff[LO_W-1:0]) * (LO_W+FRAC_W)'(rate_ff);
            phi_in    = (HI_W+FRAC_W)'(dlen_mag_ff[SMOOTH_W-1:LO_W]) * (HI_W+FRAC_W)'(rate_ff);
            pbl_in    = (2*FRAC_W)'(dbl_mag_ff) * (2*FRAC_W)'(rate_ff);
            held_l_in = $signed(mem_rd_held[2*SB-1:SB]);
            held_r_in = $signed(mem_rd_held[SB-1:0]);
            // when frozen, captured values keep what they hold and are written back unchanged
            cap_l_in  = freeze_ff ? $signed(mem_rd_cap[2*SB-1:SB]) : in_l_ff;
            cap_r_in  = freeze_ff ? $signed(mem_rd_cap[SB-1:0]) : in_r_ff;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            slen_in   = dlen_neg_ff ? (slen_ff - slen_step) : (slen_ff + slen_step);
            sblend_in = dbl_neg_ff ? (sblend_ff - sblend_step) : (sblend_ff + sblend_step);
            dl_neg_in = (cap_l_ff < held_l_ff);
            dr_neg_in = (cap_r_ff < held_r_ff);
            dl_mag_in = (cap_l_ff < held_l_ff)
                        ? SB'({held_l_ff[SB-1], held_l_ff} - {cap_l_ff[SB-1], cap_l_ff})
                        : SB'({cap_l_ff[SB-1], cap_l_ff} - {held_l_ff[SB-1], held_l_ff});
            dr_mag_in = (cap_r_ff < held_r_ff)
                        ? SB'({held_r_ff[SB-1], held_r_ff} - {cap_r_ff[SB-1], cap_r_ff})
                        : SB'({cap_r_ff[SB-1], cap_r_ff} - {held_r_ff[SB-1], held_r_ff});
            state_in  = ST_BLEND;
         end
         ST_BLEND: begin
            bl_prod_in = BP_W'(dl_mag_ff) * BP_W'(sblend_ff);
            br_prod_in = BP_W'(dr_mag_ff) * BP_W'(sblend_ff);
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            hnew_l_in = hold_l;
            hnew_r_in = hold_r;
            pos_in    = pos_wrap ? '0 : pos_next[AW-1:0];
            state_in  = ST_GAIN;
         end
         ST_GAIN: begin
            gl_prod_in = GP_W'(abs_l) * GP_W'(gain_ff);
            gr_prod_in = GP_W'(abs_r) * GP_W'(gain_ff);
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            if (out_load) begin
               if (!hnew_l_ff[SB-1]) begin
                  out_l_in = (gmag_l > POS_LIM) ? OUT_MAX : gmag_l[SB-1:0];
               end else begin
                  out_l_in = (gmag_l > NEG_LIM) ? OUT_MIN : SB'(-gmag_l[SB-1:0]);
               end
               if (!hnew_r_ff[SB-1]) begin
                  out_r_in = (gmag_r > POS_LIM) ? OUT_MAX : gmag_r[SB-1:0];
               end else begin
                  out_r_in = (gmag_r > NEG_LIM) ? OUT_MIN : SB'(-gmag_r[SB-1:0]);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tlen_ff      <= '0;
         tblend_ff    <= '0;
         rate_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         freeze_ff    <= 1'b0;
         pos_ff       <= '0;
         slen_ff      <= '0;
         sblend_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tlen_ff      <= tlen_in;
         tblend_ff    <= tblend_in;
         rate_ff      <= rate_in;
         gain_ff      <= gain_in;
         freeze_ff    <= freeze_in;
         pos_ff       <= pos_in;
         slen_ff      <= slen_in;
         sblend_ff    <= sblend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_l_ff     <= in_l_in;
      in_r_ff     <= in_r_in;
      dlen_mag_ff <= dlen_mag_in;
      dlen_neg_ff <= dlen_neg_in;
      dbl_mag_ff  <= dbl_mag_in;
      dbl_neg_ff  <= dbl_neg_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      pbl_ff      <= pbl_in;
      held_l_ff   <= held_l_in;
      held_r_ff   <= held_r_in;
      cap_l_ff    <= cap_l_in;
      cap_r_ff    <= cap_r_in;
      dl_mag_ff   <= dl_mag_in;
      dr_mag_ff   <= dr_mag_in;
      dl_neg_ff   <= dl_neg_in;
      dr_neg_ff   <= dr_neg_in;
      bl_prod_ff  <= bl_prod_in;
      br_prod_ff  <= br_prod_in;
      hnew_l_ff   <= hnew_l_in;
      hnew_r_ff   <= hnew_r_in;
      gl_prod_ff  <= gl_prod_in;
      gr_prod_ff  <= gr_prod_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

   `ASSERT_PROP(a_accept_starts, clock, reset, accept |=> (state_ff == ST_MUL1), "accepted transaction did not start the read")

   `ASSERT_PROP(a_rsp_from_sat, clock, reset, (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_SAT), "result appeared outside the saturation step")

   `ASSERT_PROP(a_pos_after_write, clock, reset, (!$past(reset) && (pos_ff != $past(pos_ff))) |-> ($past(state_ff) == ST_HOLD), "position moved without a write-back")

   `ASSERT_PROP(a_held_left_bounded, clock, reset, (state_ff == ST_GAIN) |-> (((hnew_l_ff >= held_l_ff) && (hnew_l_ff <= cap_l_ff)) || ((hnew_l_ff <= held_l_ff) && (hnew_l_ff >= cap_l_ff))), "left held value left its blend range")

   `ASSERT_NEVER(a_no_write_idle, clock, reset, mem_ctl.wr && mem_ctl.rd, "loop memory read and written in one cycle")

endmodule

`default_nettype wire
